### hdl/i2cm16_pkg.sv
package i2cm16_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // bit counter limits
  localparam logic [3:0] BYTE_LAST    = 4'd7;
  localparam logic [3:0] BYTE_BITS    = 4'd8;
  localparam logic [3:0] CLEAR_PULSES = 4'd9;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd2;

  typedef enum logic [16:0] {
    ST_IDLE    = 17'h00001,
    ST_START_W = 17'h00002,
    ST_ADDR_W  = 17'h00004,
    ST_REGH_W  = 17'h00008,
    ST_REGL_W  = 17'h00010,
    ST_WDATA   = 17'h00020,
    ST_START_R = 17'h00040,
    ST_ADDR_R  = 17'h00080,
    ST_REGH_R  = 17'h00100,
    ST_REGL_R  = 17'h00200,
    ST_RSTART  = 17'h00400,
    ST_RADDR   = 17'h00800,
    ST_RBITS   = 17'h01000,
    ST_ACK     = 17'h02000,
    ST_NACK    = 17'h04000,
    ST_STOP    = 17'h08000,
    ST_CLEAR   = 17'h10000
  } seq_state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  address_byte;
    logic [15:0] register_address;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        sda_in;
  } i2cm16_in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       write_byte_taken;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       ack_error;
    logic       done_res;
  } i2cm16_out_t;

endpackage

### hdl/i2cm16_seq.sv
module i2cm16_seq import i2cm16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_en_i,
  input  i2cm16_in_t  item_i,
  input  logic [15:0] phase_ticks_i,
  output i2cm16_out_t res_o
);

  seq_state_e  seq_q, seq_d, enter_st;
  logic        enter_en;
  logic [1:0]  step_q, step_d;
  logic [15:0] tick_q, tick_d, tick_inc, limit;
  logic [3:0]  bit_q, bit_d;
  logic [15:0] remain_q, remain_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  addr_q, addr_d;
  logic [15:0] reg_q, reg_d;
  logic        scl_q, scl_d, sda_q, sda_d;
  logic        taken, rvalid, ackerr, done;
  logic [7:0]  rbyte;

  assign limit    = (phase_ticks_i == 16'd0) ? 16'd1 : phase_ticks_i;
  assign tick_inc = tick_q + 16'd1;

  always_comb begin
    seq_d    = seq_q;
    step_d   = step_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    remain_d = remain_q;
    shift_d  = shift_q;
    addr_d   = addr_q;
    reg_d    = reg_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    taken    = 1'b0;
    rvalid   = 1'b0;
    ackerr   = 1'b0;
    done     = 1'b0;
    rbyte    = 8'd0;
    enter_en = 1'b0;
    enter_st = ST_IDLE;

    if (seq_q == ST_IDLE) begin
      if (item_i.operation != OP_NONE) begin
        addr_d   = item_i.address_byte;
        reg_d    = item_i.register_address;
        remain_d = item_i.byte_count;
        tick_d   = 16'd0;
        enter_en = 1'b1;
        unique case (item_i.operation)
          OP_WRITE: enter_st = ST_START_W;
          OP_READ:  enter_st = ST_START_R;
          OP_CLEAR: enter_st = ST_CLEAR;
          default:  enter_st = ST_IDLE;
        endcase
      end
    end else begin
      tick_d = tick_inc;
      if (tick_inc >= limit) begin
        tick_d = 16'd0;
        unique case (seq_q) inside
          ST_START_W, ST_START_R, ST_RSTART: begin
            step_d = step_q + 2'd1;
            case (step_q)
              2'd0: scl_d = 1'b1;
              2'd1: sda_d = 1'b0;
              2'd2: scl_d = 1'b0;
              default: begin
                enter_en = 1'b1;
                enter_st = (seq_q == ST_START_W) ? ST_ADDR_W :
                           (seq_q == ST_START_R) ? ST_ADDR_R : ST_RADDR;
              end
            endcase
          end
          ST_ADDR_W, ST_REGH_W, ST_REGL_W, ST_WDATA,
          ST_ADDR_R, ST_REGH_R, ST_REGL_R, ST_RADDR: begin
            if (bit_q < BYTE_BITS) begin
              if (step_q == 2'd0) begin
                scl_d  = 1'b1;
                step_d = 2'd1;
              end else if (step_q == 2'd1) begin
                scl_d = 1'b0;
                if (bit_q == BYTE_LAST) sda_d = 1'b1;
                shift_d = {shift_q[6:0], 1'b0};
                step_d  = 2'd2;
              end else begin
                bit_d  = bit_q + 4'd1;
                step_d = 2'd0;
                sda_d  = (bit_q < BYTE_LAST) ? shift_q[7] : 1'b1;
              end
            end else begin
              // ack slot
              if (step_q == 2'd0) begin
                scl_d  = 1'b1;
                step_d = 2'd1;
              end else if (step_q == 2'd1) begin
                ackerr = item_i.sda_in;
                scl_d  = 1'b0;
                step_d = 2'd2;
              end else begin
                enter_en = 1'b1;
                unique case (seq_q) inside
                  ST_ADDR_W: enter_st = ST_REGH_W;
                  ST_REGH_W: enter_st = ST_REGL_W;
                  ST_REGL_W: enter_st = (remain_q != 16'd0) ? ST_WDATA : ST_STOP;
                  ST_WDATA: begin
                    remain_d = remain_q - 16'd1;
                    enter_st = (remain_d != 16'd0) ? ST_WDATA : ST_STOP;
                  end
                  ST_ADDR_R: enter_st = ST_REGH_R;
                  ST_REGH_R: enter_st = ST_REGL_R;
                  ST_REGL_R: enter_st = ST_RSTART;
                  ST_RADDR:  enter_st = (remain_q != 16'd0) ? ST_RBITS : ST_STOP;
                  default:   enter_st = ST_IDLE;
                endcase
              end
            end
          end
          ST_RBITS: begin
            if (step_q == 2'd0) begin
              shift_d = {shift_q[6:0], item_i.sda_in};
              scl_d   = 1'b0;
              step_d  = 2'd1;
            end else begin
              bit_d = bit_q + 4'd1;
              if (bit_q < BYTE_LAST) begin
                step_d = 2'd0;
                scl_d  = 1'b1;
                sda_d  = 1'b1;
              end else begin
                rvalid   = 1'b1;
                rbyte    = shift_q;
                remain_d = remain_q - 16'd1;
                enter_en = 1'b1;
                enter_st = (remain_d != 16'd0) ? ST_ACK : ST_NACK;
              end
            end
          end
          ST_ACK: begin
            step_d = step_q + 2'd1;
            case (step_q)
              2'd0: scl_d = 1'b1;
              2'd1: scl_d = 1'b0;
              default: begin
                enter_en = 1'b1;
                enter_st = ST_RBITS;
              end
            endcase
          end
          ST_NACK: begin
            if (step_q == 2'd0) begin
              scl_d  = 1'b0;
              step_d = 2'd1;
            end else begin
              enter_en = 1'b1;
              enter_st = ST_STOP;
            end
          end
          ST_STOP: begin
            step_d = step_q + 2'd1;
            case (step_q)
              2'd0: scl_d = 1'b1;
              2'd1: sda_d = 1'b1;
              default: begin
                done     = 1'b1;
                enter_en = 1'b1;
                enter_st = ST_IDLE;
              end
            endcase
          end
          ST_CLEAR: begin
            if (step_q == 2'd0) begin
              scl_d  = 1'b0;
              step_d = 2'd1;
            end else begin
              bit_d = bit_q + 4'd1;
              if (bit_d < CLEAR_PULSES) begin
                step_d = 2'd0;
                scl_d  = 1'b1;
              end else begin
                enter_en = 1'b1;
                enter_st = ST_STOP;
              end
            end
          end
          default: begin
            enter_en = 1'b1;
            enter_st = ST_IDLE;
          end
        endcase
      end
    end

    // entry actions of the next sequence
    if (enter_en) begin
      seq_d  = enter_st;
      step_d = 2'd0;
      bit_d  = 4'd0;
      unique case (enter_st) inside
        ST_START_W, ST_START_R, ST_RSTART: sda_d = 1'b1;
        ST_ADDR_W, ST_ADDR_R: begin
          shift_d = addr_d;
          sda_d   = addr_d[7];
        end
        ST_REGH_W, ST_REGH_R: begin
          shift_d = reg_d[15:8];
          sda_d   = reg_d[15];
        end
        ST_REGL_W, ST_REGL_R: begin
          shift_d = reg_d[7:0];
          sda_d   = reg_d[7];
        end
        ST_WDATA: begin
          taken   = 1'b1;
          shift_d = item_i.write_byte;
          sda_d   = item_i.write_byte[7];
        end
        ST_RADDR: begin
          shift_d = addr_d | 8'h01;
          sda_d   = addr_d[7];
        end
        ST_RBITS: begin
          shift_d = 8'd0;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
        end
        ST_ACK:   sda_d = 1'b0;
        ST_NACK: begin
          sda_d = 1'b1;
          scl_d = 1'b1;
        end
        ST_STOP:  sda_d = 1'b0;
        ST_CLEAR: scl_d = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= ST_IDLE;
      step_q   <= 2'd0;
      tick_q   <= 16'd0;
      bit_q    <= 4'd0;
      remain_q <= 16'd0;
      shift_q  <= 8'd0;
      addr_q   <= 8'd0;
      reg_q    <= 16'd0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
    end else if (step_en_i) begin
      seq_q    <= seq_d;
      step_q   <= step_d;
      tick_q   <= tick_d;
      bit_q    <= bit_d;
      remain_q <= remain_d;
      shift_q  <= shift_d;
      addr_q   <= addr_d;
      reg_q    <= reg_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
    end
  end

  always_comb begin
    res_o                  = '0;
    res_o.scl_out          = scl_d;
    res_o.sda_out          = sda_d;
    res_o.busy_res         = (seq_d != ST_IDLE);
    res_o.write_byte_taken = taken;
    res_o.read_valid       = rvalid;
    res_o.read_byte        = rbyte;
    res_o.ack_error        = ackerr;
    res_o.done_res         = done;
  end

  // bus is released whenever the sequencer rests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == ST_IDLE) |-> (scl_q && sda_q))
    else $error("bus not released while idle");

  // only start conditions use the fourth phase step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == 2'd3) |->
      (seq_q == ST_START_W || seq_q == ST_START_R || seq_q == ST_RSTART))
    else $error("fourth phase step outside a start condition");

  // a completed stop leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en_i && res_o.done_res) |=> (seq_q == ST_IDLE))
    else $error("stop completed but sequencer not idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= CLEAR_PULSES)
    else $error("bit counter out of range");

endmodule

### hdl/i2c_master_reg16_transfer.sv
// i2c master for devices with a 16-bit register address. every input beat is
// one base timer tick carrying the sampled sda level and, while idle, an
// operation (write transfer, read transfer or bus clear) with its device
// address, register address and byte count. every input beat yields exactly
// one result beat with the scl/sda drive levels and status strobes for that
// tick. pin phases last phase_ticks ticks (zero counts as one), set through
// the configuration port; the user must write it only while the block is idle,
// the block does not enforce this. the reset value is 2. data bytes for a write
// are taken from write_byte on the tick write_byte_taken is set, received bytes
// appear with read_valid. a missing ack only pulses ack_error. throughput is one
// tick per clock cycle while the result side does not stall; a beat passes
// through an input register and a result register, and the sequencer state
// update for one tick is the single combinational step between them.
module i2c_master_reg16_transfer import i2cm16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: phase_ticks
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // tick beats in
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  i2cm16_in_t  in_data_i,
  // result beats out
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output i2cm16_out_t out_data_o
);

  logic        in_valid_q;
  i2cm16_in_t  in_q;
  logic        out_valid_q;
  i2cm16_out_t out_q;
  logic [15:0] phase_ticks_q;
  logic        proc;
  logic        in_acc;
  i2cm16_out_t res;

  // a held beat is processed when the result register is free or draining
  assign proc       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RST;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
  end

  // one tick of the bus sequencer
  i2cm16_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (proc),
    .item_i        (in_q),
    .phase_ticks_i (phase_ticks_q),
    .res_o         (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### tb/sv/tb_i2c_master_reg16_transfer.sv
`timescale 1ns / 100ps

module tb_i2c_master_reg16_transfer;
  import i2cm16_pkg::*;

  // run limits
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int MAX_REPORTS  = 100;

  logic        clk_i;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall_o;
  i2cm16_in_t  in_data;
  logic        out_valid_o;
  logic        out_stall;
  i2cm16_out_t out_data_o;

  i2c_master_reg16_transfer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  // expected pin levels and strobes, one entry per accepted tick beat
  i2cm16_out_t tick_results_q[$];

  int errors;
  int cycle_count;
  int sda_high_pct;
  int burst_left;

  // run statistics, taken from the predicted beats
  int n_ticks, n_writes, n_reads, n_clears;
  int n_bytes_read, n_bytes_taken, n_ack_errors, n_stops;

  // ------------------------------------------------------------------
  // sequencer predictor: own copy of the block state
  // ------------------------------------------------------------------
  logic [15:0] m_phase_ticks;
  seq_state_e  m_state;
  logic [1:0]  m_step;
  logic [15:0] m_ticks;
  logic [3:0]  m_bits;
  logic [15:0] m_remaining;
  logic [7:0]  m_shift;
  logic [7:0]  m_address;
  logic [15:0] m_register;
  logic        m_scl;
  logic        m_sda;

  // per-tick inputs and strobes
  logic [7:0]  s_wbyte;
  logic        s_sda_in;
  logic        s_taken, s_valid, s_ackerr, s_done;
  logic [7:0]  s_read;

  function automatic void load_send(input logic [7:0] b);
    m_shift = b;
    m_sda   = b[7];
  endfunction

  function automatic void enter_seq(input seq_state_e st);
    m_state = st;
    m_step  = 2'd0;
    m_bits  = 4'd0;
    case (st)
      ST_START_W, ST_START_R, ST_RSTART: m_sda = 1'b1;
      ST_ADDR_W, ST_ADDR_R: load_send(m_address);
      ST_REGH_W, ST_REGH_R: load_send(m_register[15:8]);
      ST_REGL_W, ST_REGL_R: load_send(m_register[7:0]);
      ST_WDATA: begin
        s_taken = 1'b1;
        load_send(s_wbyte);
      end
      ST_RADDR: load_send(m_address | 8'h01);
      ST_RBITS: begin
        m_shift = 8'h00;
        m_scl   = 1'b1;
        m_sda   = 1'b1;
      end
      ST_ACK:  m_sda = 1'b0;
      ST_NACK: begin
        m_sda = 1'b1;
        m_scl = 1'b1;
      end
      ST_STOP:  m_sda = 1'b0;
      ST_CLEAR: m_scl = 1'b1;
      default: ;
    endcase
  endfunction

  // end of a sequence element: pick the next one
  function automatic void finish_seq();
    case (m_state)
      ST_START_W: enter_seq(ST_ADDR_W);
      ST_ADDR_W:  enter_seq(ST_REGH_W);
      ST_REGH_W:  enter_seq(ST_REGL_W);
      ST_REGL_W:  enter_seq(m_remaining != 16'd0 ? ST_WDATA : ST_STOP);
      ST_WDATA: begin
        m_remaining = m_remaining - 16'd1;
        enter_seq(m_remaining != 16'd0 ? ST_WDATA : ST_STOP);
      end
      ST_START_R: enter_seq(ST_ADDR_R);
      ST_ADDR_R:  enter_seq(ST_REGH_R);
      ST_REGH_R:  enter_seq(ST_REGL_R);
      ST_REGL_R:  enter_seq(ST_RSTART);
      ST_RSTART:  enter_seq(ST_RADDR);
      ST_RADDR:   enter_seq(m_remaining != 16'd0 ? ST_RBITS : ST_STOP);
      ST_RBITS: begin
        s_valid     = 1'b1;
        s_read      = m_shift;
        m_remaining = m_remaining - 16'd1;
        enter_seq(m_remaining != 16'd0 ? ST_ACK : ST_NACK);
      end
      ST_ACK:   enter_seq(ST_RBITS);
      ST_NACK:  enter_seq(ST_STOP);
      ST_CLEAR: enter_seq(ST_STOP);
      ST_STOP: begin
        s_done = 1'b1;
        enter_seq(ST_IDLE);
      end
      default: enter_seq(ST_IDLE);
    endcase
  endfunction

  function automatic bit is_send(input seq_state_e st);
    case (st)
      ST_ADDR_W, ST_REGH_W, ST_REGL_W, ST_WDATA,
      ST_ADDR_R, ST_REGH_R, ST_REGL_R, ST_RADDR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // one pin phase of the current sequence element
  function automatic void advance_phase();
    if (m_state == ST_START_W || m_state == ST_START_R || m_state == ST_RSTART) begin
      case (m_step)
        2'd0: m_scl = 1'b1;
        2'd1: m_sda = 1'b0;
        2'd2: m_scl = 1'b0;
        default: begin
          finish_seq();
          return;
        end
      endcase
      m_step = m_step + 2'd1;
    end else if (is_send(m_state)) begin
      if (m_bits < BYTE_BITS) begin
        if (m_step == 2'd0) begin
          m_scl  = 1'b1;
          m_step = 2'd1;
        end else if (m_step == 2'd1) begin
          m_scl = 1'b0;
          if (m_bits == BYTE_LAST) m_sda = 1'b1;
          m_shift = m_shift << 1;
          m_step  = 2'd2;
        end else begin
          m_bits = m_bits + 4'd1;
          m_step = 2'd0;
          m_sda  = (m_bits < BYTE_BITS) ? m_shift[7] : 1'b1;
        end
      end else begin
        // ack slot of a sent byte
        if (m_step == 2'd0) begin
          m_scl  = 1'b1;
          m_step = 2'd1;
        end else if (m_step == 2'd1) begin
          if (s_sda_in) s_ackerr = 1'b1;
          m_scl  = 1'b0;
          m_step = 2'd2;
        end else begin
          finish_seq();
        end
      end
    end else if (m_state == ST_RBITS) begin
      if (m_step == 2'd0) begin
        m_shift = {m_shift[6:0], s_sda_in};
        m_scl   = 1'b0;
        m_step  = 2'd1;
      end else begin
        m_bits = m_bits + 4'd1;
        if (m_bits < BYTE_BITS) begin
          m_step = 2'd0;
          m_scl  = 1'b1;
          m_sda  = 1'b1;
        end else begin
          finish_seq();
        end
      end
    end else if (m_state == ST_ACK) begin
      case (m_step)
        2'd0: m_scl = 1'b1;
        2'd1: m_scl = 1'b0;
        default: begin
          finish_seq();
          return;
        end
      endcase
      m_step = m_step + 2'd1;
    end else if (m_state == ST_NACK) begin
      if (m_step == 2'd0) begin
        m_scl  = 1'b0;
        m_step = 2'd1;
      end else begin
        finish_seq();
      end
    end else if (m_state == ST_STOP) begin
      case (m_step)
        2'd0: m_scl = 1'b1;
        2'd1: m_sda = 1'b1;
        default: begin
          finish_seq();
          return;
        end
      endcase
      m_step = m_step + 2'd1;
    end else if (m_state == ST_CLEAR) begin
      if (m_step == 2'd0) begin
        m_scl  = 1'b0;
        m_step = 2'd1;
      end else begin
        m_bits = m_bits + 4'd1;
        if (m_bits < CLEAR_PULSES) begin
          m_step = 2'd0;
          m_scl  = 1'b1;
        end else begin
          finish_seq();
        end
      end
    end else begin
      enter_seq(ST_IDLE);
    end
  endfunction

  // one timer tick: returns the expected result beat
  function automatic i2cm16_out_t predict_tick(input i2cm16_in_t t);
    logic [15:0] limit;
    i2cm16_out_t r;
    limit    = (m_phase_ticks != 16'd0) ? m_phase_ticks : 16'd1;
    s_wbyte  = t.write_byte;
    s_sda_in = t.sda_in;
    s_taken  = 1'b0;
    s_valid  = 1'b0;
    s_ackerr = 1'b0;
    s_done   = 1'b0;
    s_read   = 8'h00;
    if (m_state == ST_IDLE) begin
      if (t.operation != OP_NONE) begin
        m_address   = t.address_byte;
        m_register  = t.register_address;
        m_remaining = t.byte_count;
        m_ticks     = 16'd0;
        case (t.operation)
          OP_WRITE: begin
            n_writes++;
            enter_seq(ST_START_W);
          end
          OP_READ: begin
            n_reads++;
            enter_seq(ST_START_R);
          end
          default: begin
            n_clears++;
            enter_seq(ST_CLEAR);
          end
        endcase
      end
    end else begin
      m_ticks = m_ticks + 16'd1;
      if (m_ticks >= limit) begin
        m_ticks = 16'd0;
        advance_phase();
      end
    end
    r.scl_out          = m_scl;
    r.sda_out          = m_sda;
    r.busy_res         = (m_state != ST_IDLE);
    r.write_byte_taken = s_taken;
    r.read_valid       = s_valid;
    r.read_byte        = s_valid ? s_read : 8'h00;
    r.ack_error        = s_ackerr;
    r.done_res         = s_done;
    return r;
  endfunction

  // ------------------------------------------------------------------
  // clock, cycle limit
  // ------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t timeout, %0d result beats still pending", $time, tick_results_q.size());
      $display("i2c_master_reg16_transfer test failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // receiver: stall pattern in stretches of free flow, random and periodic
  // ------------------------------------------------------------------
  initial begin : stall_pattern
    int left;
    int mode;
    left = 0;
    mode = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(10, 60);
      end
      left--;
      case (mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ((left % 8) < 3);
      endcase
    end
  end

  // ------------------------------------------------------------------
  // result checker: every accepted result beat against the oldest expectation
  // ------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      if (errors < MAX_REPORTS)
        $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    i2cm16_out_t want;
    if (rst_n && out_valid_o === 1'b1 && !out_stall) begin
      if (tick_results_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t result beat with nothing expected, actual %h", $time, out_data_o);
        errors++;
      end else begin
        want = tick_results_q.pop_front();
        check_field("scl_out", 8'(want.scl_out), 8'(out_data_o.scl_out));
        check_field("sda_out", 8'(want.sda_out), 8'(out_data_o.sda_out));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data_o.busy_res));
        check_field("write_byte_taken", 8'(want.write_byte_taken),
                    8'(out_data_o.write_byte_taken));
        check_field("read_valid", 8'(want.read_valid), 8'(out_data_o.read_valid));
        check_field("read_byte", want.read_byte, out_data_o.read_byte);
        check_field("ack_error", 8'(want.ack_error), 8'(out_data_o.ack_error));
        check_field("done_res", 8'(want.done_res), 8'(out_data_o.done_res));
      end
    end
  end

  // ------------------------------------------------------------------
  // sender side
  // ------------------------------------------------------------------

  // all fields random, sda level biased by sda_high_pct
  function automatic i2cm16_in_t random_tick();
    i2cm16_in_t t;
    t.operation        = 2'($urandom);
    t.address_byte     = 8'($urandom);
    t.register_address = 16'($urandom);
    t.byte_count       = 16'($urandom);
    t.write_byte       = 8'($urandom);
    t.sda_in           = ($urandom_range(0, 99) < sda_high_pct);
    return t;
  endfunction

  // one tick beat: hold it until accepted, then predict its result
  task automatic send_tick(input i2cm16_in_t t);
    i2cm16_out_t want;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk_i); while (in_stall_o);
    want = predict_tick(t);
    tick_results_q.push_back(want);
    n_ticks++;
    if (want.read_valid) n_bytes_read++;
    if (want.write_byte_taken) n_bytes_taken++;
    if (want.ack_error) n_ack_errors++;
    if (want.done_res) n_stops++;
  endtask

  // bursts of random length, sometimes with a gap of random length after them
  task automatic pace();
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 1) == 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // ticks that carry no operation while the bus is idle
  task automatic idle_ticks(input int n);
    i2cm16_in_t t;
    repeat (n) begin
      t = random_tick();
      t.operation = OP_NONE;
      pace();
      send_tick(t);
    end
  endtask

  // start one operation, then feed random ticks until the stop completes;
  // ticks while busy carry random operations that must be ignored
  task automatic run_operation(input logic [1:0] op, input logic [7:0] addr,
                               input logic [15:0] regaddr, input logic [15:0] count);
    i2cm16_in_t t;
    t = random_tick();
    t.operation        = op;
    t.address_byte     = addr;
    t.register_address = regaddr;
    t.byte_count       = count;
    pace();
    send_tick(t);
    while (m_state != ST_IDLE) begin
      pace();
      send_tick(random_tick());
    end
  endtask

  // sender pauses until every expected result beat has arrived
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (tick_results_q.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // phase_ticks is only written with the bus idle and nothing in flight
  task automatic write_phase_ticks(input logic [15:0] value);
    wait_all_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    m_phase_ticks = value;
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------
  task automatic test_idle_ticks();
    // no operation requested: lines stay released, nothing strobes
    idle_ticks(6);
  endtask

  task automatic test_bus_clear();
    // reset phase setting; nine pulses leave sda where it was, then stop
    run_operation(OP_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom));
    idle_ticks(3);
  endtask

  task automatic test_write_transfers();
    write_phase_ticks(16'd1);
    sda_high_pct = 50;
    // two data bytes back to back
    run_operation(OP_WRITE, 8'hA0, 16'h1234, 16'd2);
    // field extremes, every ack slot missing, zero count goes straight to stop
    sda_high_pct = 100;
    run_operation(OP_WRITE, 8'hFF, 16'hFFFF, 16'd0);
    sda_high_pct = 50;
  endtask

  task automatic test_read_transfers();
    // zero phase setting behaves as one tick per phase
    write_phase_ticks(16'd0);
    run_operation(OP_READ, 8'hA0, 16'h00FF, 16'd2);
    // clean bus, zero count read stops after the second address byte
    sda_high_pct = 0;
    run_operation(OP_READ, 8'hFF, 16'hFF00, 16'd0);
    sda_high_pct = 50;
  endtask

  task automatic test_phase_settings();
    write_phase_ticks(16'd3);
    run_operation(OP_CLEAR, 8'h00, 16'h0000, 16'd0);
    // widest setting only held while idle, a full sequence would take millions of ticks
    write_phase_ticks(16'hFFFF);
    idle_ticks(8);
    write_phase_ticks(PHASE_TICKS_RST);
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin : main_sequence
    errors       = 0;
    cycle_count  = 0;
    burst_left   = 0;
    sda_high_pct = 50;
    n_ticks = 0;  n_writes = 0;  n_reads = 0;  n_clears = 0;
    n_bytes_read = 0;  n_bytes_taken = 0;  n_ack_errors = 0;  n_stops = 0;

    // predictor reset state: idle, both lines released
    m_phase_ticks = PHASE_TICKS_RST;
    m_state       = ST_IDLE;
    m_step        = 2'd0;
    m_ticks       = 16'd0;
    m_bits        = 4'd0;
    m_remaining   = 16'd0;
    m_shift       = 8'h00;
    m_address     = 8'h00;
    m_register    = 16'h0000;
    m_scl         = 1'b1;
    m_sda         = 1'b1;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= PHASE_TICKS_RST;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_bus_clear();
    test_write_transfers();
    test_read_transfers();
    test_phase_settings();

    // drain, then keep watching for anything stray
    wait_all_results();
    repeat (10) @(posedge clk_i);

    $display("ran %0d tick beats: %0d writes, %0d reads, %0d bus clears, %0d stops",
             n_ticks, n_writes, n_reads, n_clears, n_stops);
    $display("%0d bytes sent from write_byte, %0d bytes received, %0d missing acks flagged",
             n_bytes_taken, n_bytes_read, n_ack_errors);
    if (errors == 0) begin
      $display("i2c_master_reg16_transfer test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("i2c_master_reg16_transfer test failed");
    end
    $finish;
  end

endmodule
